### hw/rtl/hd44780_nibble_interface_ctrl_top_defines.svh
// assertion macros for the hd44780 nibble interface controller
`ifndef HD44780_NIBBLE_INTERFACE_CTRL_TOP_DEFINES_SVH
`define HD44780_NIBBLE_INTERFACE_CTRL_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HNIC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define HNIC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/hnic_pkg.sv
// shared types, codes and constants of the hd44780 nibble interface controller
package hnic_pkg;

  // request codes
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_CMD  = 2'd1;
  localparam logic [1:0] OP_DATA = 2'd2;
  localparam logic [1:0] OP_CURS = 2'd3;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_PWR_WAIT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_GAP1     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_GAP2     = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_PULSE    = 2'd3;
  localparam int unsigned CfgDataW = 16;

  // register reset values
  localparam logic [15:0] PWR_WAIT_RST = 16'd20000;
  localparam logic [15:0] GAP1_RST     = 16'd5000;
  localparam logic [15:0] GAP2_RST     = 16'd150;
  localparam logic [7:0]  PULSE_RST    = 8'd1;

  // init sequence bookkeeping
  localparam logic [3:0] IDX_FIRST_CMD = 4'd4;
  localparam logic [3:0] IDX_LAST_CMD  = 4'd7;
  localparam logic [3:0] IDX_DONE      = 4'd8;
  localparam logic [3:0] NIB_WAKE      = 4'h3;
  localparam logic [3:0] NIB_4BIT      = 4'h2;
  localparam logic [7:0] SET_DDRAM     = 8'h80;
  localparam logic [6:0] ROW1_BASE     = 7'h40;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] byte_in;
    logic       row;
    logic [5:0] col;
    logic [3:0] pins_in;
  } in_word_t;

  typedef struct packed {
    logic       rs_pin;
    logic       rw_pin;
    logic       en_pin;
    logic [3:0] data_out;
    logic       data_drive;
    logic       ready_res;
    logic       init_done;
  } out_word_t;

  // power-up command list: function set, display on, entry mode, clear
  function automatic logic [7:0] init_cmd(input logic [1:0] sel);
    logic [7:0] cmd;
    case (sel)
      2'd0:    cmd = 8'h28;
      2'd1:    cmd = 8'h0C;
      2'd2:    cmd = 8'h06;
      default: cmd = 8'h01;
    endcase
    return cmd;
  endfunction

endpackage

### hw/rtl/hd44780_nibble_interface_ctrl_top.sv
// hd44780 4-bit bus controller: one tick word in, one pin-level word out
//
//  port group   | dir | handshake                 | word
//  -------------+-----+---------------------------+------------------------
//  in_*         | in  | in_valid_i / in_stall_o   | tick and request
//  out_*        | out | out_valid_o / out_stall_i | pin levels and status
//  cfg_*        | in  | cfg_we_i (write only)     | timing register
//
//  one word per cycle while in_stall_o is low: the sequencer state steps on each
//  accepted word and its pin word is registered in the main or the skid entry
//  a two-entry output (main plus skid) lets a word enter while a result waits;
//  in_stall_o rises only once both entries are full
//  reset puts the sequencer in the power-up wait with the register defaults
`include "hd44780_nibble_interface_ctrl_top_defines.svh"

module hd44780_nibble_interface_ctrl_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  hnic_pkg::in_word_t             in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output hnic_pkg::out_word_t            out_word_o,
  input  logic                           cfg_we_i,
  input  logic [hnic_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [hnic_pkg::CfgDataW-1:0]  cfg_data_i
);

  typedef enum logic [3:0] {
    PH_PWR, PH_I_EH, PH_I_EL, PH_GAP,
    PH_B1_EH, PH_B1_EL, PH_B2_EH, PH_B2_EL,
    PH_H_EH, PH_H_EL, PH_L_EH, PH_L_EL, PH_IDLE
  } phase_e;

  // configuration registers
  logic [15:0] pwr_wait_q, gap1_q, gap2_q;
  logic [7:0]  pulse_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwr_wait_q <= hnic_pkg::PWR_WAIT_RST;
      gap1_q     <= hnic_pkg::GAP1_RST;
      gap2_q     <= hnic_pkg::GAP2_RST;
      pulse_q    <= hnic_pkg::PULSE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hnic_pkg::CFG_PWR_WAIT: pwr_wait_q <= cfg_data_i;
        hnic_pkg::CFG_GAP1:     gap1_q     <= cfg_data_i;
        hnic_pkg::CFG_GAP2:     gap2_q     <= cfg_data_i;
        hnic_pkg::CFG_PULSE:    pulse_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  phase_e      phase_q, phase_d, phase_eff;
  logic [15:0] delay_q, delay_d, delay_eff;
  logic [7:0]  pend_byte_q, pend_byte_d, pend_byte_eff;
  logic        pend_rs_q, pend_rs_d, pend_rs_eff;
  logic [3:0]  init_idx_q, init_idx_d;
  logic        busy_q, busy_d;

  logic [15:0] phase_len;
  logic [3:0]  init_nib;
  logic [6:0]  curs_addr;
  hnic_pkg::out_word_t res;

  logic in_acc, out_take;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_take = out_valid_o && !out_stall_i;

  // request pickup, pin levels and phase advance for one tick
  always_comb begin
    phase_eff     = phase_q;
    delay_eff     = delay_q;
    pend_byte_eff = pend_byte_q;
    pend_rs_eff   = pend_rs_q;
    curs_addr     = in_word_i.row ? (hnic_pkg::ROW1_BASE + {1'b0, in_word_i.col})
                                  : {1'b0, in_word_i.col};

    // a request is only taken while idle
    if (phase_q == PH_IDLE && in_word_i.op != hnic_pkg::OP_TICK) begin
      if (in_word_i.op == hnic_pkg::OP_CURS) begin
        pend_byte_eff = hnic_pkg::SET_DDRAM | {1'b0, curs_addr};
        pend_rs_eff   = 1'b0;
      end else begin
        pend_byte_eff = in_word_i.byte_in;
        pend_rs_eff   = (in_word_i.op == hnic_pkg::OP_DATA);
      end
      phase_eff = PH_B1_EH;
      delay_eff = '0;
    end

    init_nib = (init_idx_q < 4'd3) ? hnic_pkg::NIB_WAKE : hnic_pkg::NIB_4BIT;

    // pin levels of this tick
    res            = '0;
    res.data_drive = 1'b1;
    case (phase_eff)
      PH_PWR: ;
      PH_I_EH: begin
        res.en_pin   = 1'b1;
        res.data_out = init_nib;
      end
      PH_I_EL: res.data_out = init_nib;
      PH_GAP:  res.data_out = hnic_pkg::NIB_WAKE;
      PH_B1_EH, PH_B2_EH: begin
        res.rw_pin     = 1'b1;
        res.en_pin     = 1'b1;
        res.data_drive = 1'b0;
      end
      PH_B1_EL, PH_B2_EL: begin
        res.rw_pin     = 1'b1;
        res.data_drive = 1'b0;
      end
      PH_H_EH: begin
        res.rs_pin   = pend_rs_eff;
        res.en_pin   = 1'b1;
        res.data_out = pend_byte_eff[7:4];
      end
      PH_H_EL: begin
        res.rs_pin   = pend_rs_eff;
        res.data_out = pend_byte_eff[7:4];
      end
      PH_L_EH: begin
        res.rs_pin   = pend_rs_eff;
        res.en_pin   = 1'b1;
        res.data_out = pend_byte_eff[3:0];
      end
      default: begin
        res.rs_pin   = pend_rs_eff;
        res.data_out = pend_byte_eff[3:0];
      end
    endcase

    // length of the current phase
    case (phase_eff)
      PH_PWR:  phase_len = pwr_wait_q;
      PH_GAP:  phase_len = (init_idx_q == 4'd0) ? gap1_q : gap2_q;
      default: phase_len = {8'd0, pulse_q};
    endcase

    // phase advance once its length is reached
    phase_d     = phase_eff;
    delay_d     = delay_eff;
    pend_byte_d = pend_byte_eff;
    pend_rs_d   = pend_rs_eff;
    init_idx_d  = init_idx_q;
    busy_d      = busy_q;
    if (phase_eff != PH_IDLE) begin
      if ({1'b0, delay_eff} + 17'd1 >= {1'b0, phase_len}) begin
        delay_d = '0;
        case (phase_eff)
          PH_PWR: begin
            phase_d    = PH_I_EH;
            init_idx_d = '0;
          end
          PH_I_EH: phase_d = PH_I_EL;
          PH_I_EL: begin
            if (init_idx_q < 4'd2) begin
              phase_d = PH_GAP;
            end else if (init_idx_q == 4'd2) begin
              init_idx_d = 4'd3;
              phase_d    = PH_I_EH;
            end else begin
              init_idx_d  = hnic_pkg::IDX_FIRST_CMD;
              pend_byte_d = hnic_pkg::init_cmd(2'd0);
              pend_rs_d   = 1'b0;
              phase_d     = PH_B1_EH;
            end
          end
          PH_GAP: begin
            init_idx_d = init_idx_q + 4'd1;
            phase_d    = PH_I_EH;
          end
          PH_B1_EH: begin
            busy_d  = in_word_i.pins_in[3];
            phase_d = PH_B1_EL;
          end
          PH_B1_EL: phase_d = PH_B2_EH;
          PH_B2_EH: phase_d = PH_B2_EL;
          PH_B2_EL: phase_d = busy_q ? PH_B1_EH : PH_H_EH;
          PH_H_EH:  phase_d = PH_H_EL;
          PH_H_EL:  phase_d = PH_L_EH;
          PH_L_EH:  phase_d = PH_L_EL;
          PH_L_EL: begin
            if (init_idx_q >= hnic_pkg::IDX_FIRST_CMD &&
                init_idx_q < hnic_pkg::IDX_LAST_CMD) begin
              init_idx_d  = init_idx_q + 4'd1;
              pend_byte_d = hnic_pkg::init_cmd(init_idx_q[1:0] + 2'd1);
              pend_rs_d   = 1'b0;
              phase_d     = PH_B1_EH;
            end else begin
              if (init_idx_q == hnic_pkg::IDX_LAST_CMD) begin
                init_idx_d = hnic_pkg::IDX_DONE;
              end
              phase_d = PH_IDLE;
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end else begin
        delay_d = delay_eff + 16'd1;
      end
    end

    res.ready_res = (phase_d == PH_IDLE);
    res.init_done = (init_idx_d >= hnic_pkg::IDX_DONE);
  end

  // state steps on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_PWR;
      delay_q     <= '0;
      pend_byte_q <= '0;
      pend_rs_q   <= 1'b0;
      init_idx_q  <= '0;
      busy_q      <= 1'b0;
    end else if (in_acc) begin
      phase_q     <= phase_d;
      delay_q     <= delay_d;
      pend_byte_q <= pend_byte_d;
      pend_rs_q   <= pend_rs_d;
      init_idx_q  <= init_idx_d;
      busy_q      <= busy_d;
    end
  end

  // output register with skid entry
  logic                main_valid_q, skid_valid_q;
  hnic_pkg::out_word_t main_q, skid_q;

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_word_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_acc) begin
      if (main_valid_q && !out_take) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      main_valid_q <= 1'b0;
    end
  end

  // result words, no reset needed
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        main_q <= skid_q;
      end
    end else if (in_acc) begin
      if (main_valid_q && !out_take) begin
        skid_q <= res;
      end else begin
        main_q <= res;
      end
    end
  end

  // checks
  `HNIC_ASSERT_NOW(a_skid_implies_main, clk_i, rst_ni,
    skid_valid_q, main_valid_q, "skid entry full while main entry empty")
  `HNIC_ASSERT_NEXT(a_fill_skid, clk_i, rst_ni,
    in_acc && main_valid_q && out_stall_i, skid_valid_q, "stalled result not kept in skid")
  `HNIC_ASSERT_NOW(a_idle_no_count, clk_i, rst_ni,
    phase_q == PH_IDLE, delay_q == 16'd0, "delay counter running while idle")
  `HNIC_ASSERT_NEXT(a_init_sticky, clk_i, rst_ni,
    init_idx_q == hnic_pkg::IDX_DONE, init_idx_q == hnic_pkg::IDX_DONE,
    "init done flag cleared")

endmodule
